>>> hdl/cndc_pkg.sv
// Shared types, constants and local oscillator tables for the carrier NCO downconverter.
`timescale 1ns / 1ps

package cndc_pkg;

    localparam int PHASE_W    = 32;
    localparam int CYCLES_W   = 32;
    localparam int TBL_IDX_W  = 6;
    localparam int TBL_DEPTH  = 1 << TBL_IDX_W;
    localparam int COEF_W     = 5;
    localparam int MIXED_W    = 6;
    localparam int M_TDATA_W  = ((2 * MIXED_W + CYCLES_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - 2 * MIXED_W - CYCLES_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_FREQ_WORD = 1'b0;
    localparam logic REG_PRE_SHIFT = 1'b1;

    // Scaling codes.
    localparam logic [1:0] SHIFT_TRUNC3 = 2'd3;
    localparam logic [2:0] BASE_SHIFT   = 3'd3;

    typedef logic signed [COEF_W-1:0] t_coef;

    // Oscillator tap for one sample: coefficient pair and the updated cycle count.
    typedef struct packed {
        t_coef               lo_cos;
        t_coef               lo_nsin;
        logic [CYCLES_W-1:0] cycles;
    } t_nco_tap;

    localparam t_coef LO_COS [TBL_DEPTH] = '{
         5'sd12,  5'sd12,  5'sd12,  5'sd11,  5'sd11,  5'sd10,  5'sd10,  5'sd9,
         5'sd8,   5'sd7,   5'sd6,   5'sd5,   5'sd4,   5'sd3,   5'sd2,   5'sd1,
        -5'sd1,  -5'sd2,  -5'sd3,  -5'sd4,  -5'sd5,  -5'sd6,  -5'sd7,  -5'sd8,
        -5'sd9,  -5'sd10, -5'sd10, -5'sd11, -5'sd11, -5'sd12, -5'sd12, -5'sd12,
        -5'sd12, -5'sd12, -5'sd12, -5'sd11, -5'sd11, -5'sd10, -5'sd10, -5'sd9,
        -5'sd8,  -5'sd7,  -5'sd6,  -5'sd5,  -5'sd4,  -5'sd3,  -5'sd2,  -5'sd1,
         5'sd1,   5'sd2,   5'sd3,   5'sd4,   5'sd5,   5'sd6,   5'sd7,   5'sd8,
         5'sd9,   5'sd10,  5'sd10,  5'sd11,  5'sd11,  5'sd12,  5'sd12,  5'sd12
    };

    localparam t_coef LO_NSIN [TBL_DEPTH] = '{
        -5'sd1,  -5'sd2,  -5'sd3,  -5'sd4,  -5'sd5,  -5'sd6,  -5'sd7,  -5'sd8,
        -5'sd9,  -5'sd10, -5'sd10, -5'sd11, -5'sd11, -5'sd12, -5'sd12, -5'sd12,
        -5'sd12, -5'sd12, -5'sd12, -5'sd11, -5'sd11, -5'sd10, -5'sd10, -5'sd9,
        -5'sd8,  -5'sd7,  -5'sd6,  -5'sd5,  -5'sd4,  -5'sd3,  -5'sd2,  -5'sd1,
         5'sd1,   5'sd2,   5'sd3,   5'sd4,   5'sd5,   5'sd6,   5'sd7,   5'sd8,
         5'sd9,   5'sd10,  5'sd10,  5'sd11,  5'sd11,  5'sd12,  5'sd12,  5'sd12,
         5'sd12,  5'sd12,  5'sd12,  5'sd11,  5'sd11,  5'sd10,  5'sd10,  5'sd9,
         5'sd8,   5'sd7,   5'sd6,   5'sd5,   5'sd4,   5'sd3,   5'sd2,   5'sd1
    };

endpackage

>>> hdl/cndc_nco.sv
// Carrier phase accumulator, cycle counter and oscillator table lookup.
`timescale 1ns / 1ps

module cndc_nco (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [cndc_pkg::PHASE_W-1:0] i_freq_word,
    output cndc_pkg::t_nco_tap           o_tap
);

    logic [cndc_pkg::PHASE_W-1:0]   r_phase;
    logic [cndc_pkg::PHASE_W-1:0]   n_phase;
    logic [cndc_pkg::CYCLES_W-1:0]  r_cycles;
    logic [cndc_pkg::CYCLES_W-1:0]  n_cycles;
    logic                           carry;
    logic [cndc_pkg::TBL_IDX_W-1:0] idx;

    assign {carry, n_phase} = {1'b0, r_phase} + {1'b0, i_freq_word};

    // Count up on a wrap for positive words, down when the phase moves up on negative ones.
    always_comb begin
        n_cycles = r_cycles;
        if (i_freq_word[cndc_pkg::PHASE_W-1]) begin
            if (n_phase > r_phase) begin
                n_cycles = r_cycles - cndc_pkg::CYCLES_W'(1);
            end
        end else if (carry) begin
            n_cycles = r_cycles + cndc_pkg::CYCLES_W'(1);
        end
    end

    assign idx = r_phase[cndc_pkg::PHASE_W-1 -: cndc_pkg::TBL_IDX_W];

    always_comb begin
        o_tap.lo_cos  = cndc_pkg::LO_COS[idx];
        o_tap.lo_nsin = cndc_pkg::LO_NSIN[idx];
        o_tap.cycles  = n_cycles;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_cycles <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_cycles <= n_cycles;
        end
    end

endmodule

>>> hdl/cndc_mixer.sv
// Complex mixer with selectable scaling and symmetric saturation.
`timescale 1ns / 1ps

module cndc_mixer #(
    parameter int SAMPLE_BITS = 8
) (
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_im,
    input  cndc_pkg::t_coef                      i_lo_cos,
    input  cndc_pkg::t_coef                      i_lo_nsin,
    input  logic [1:0]                           i_shift_mode,
    output logic signed [cndc_pkg::MIXED_W-1:0]  o_mixed_re,
    output logic signed [cndc_pkg::MIXED_W-1:0]  o_mixed_im
);

    localparam int P_W = SAMPLE_BITS + cndc_pkg::COEF_W + 1;

    logic signed [P_W-1:0] a;
    logic signed [P_W-1:0] b;
    logic signed [P_W-1:0] c;
    logic signed [P_W-1:0] d;
    logic signed [P_W-1:0] re_sum;
    logic signed [P_W-1:0] im_sum;
    logic [2:0]            sh;
    logic                  conv;

    function automatic logic signed [cndc_pkg::MIXED_W-1:0] scale_sat(
        input logic signed [P_W-1:0] x,
        input logic [2:0]            n,
        input logic                  rnd
    );
        logic signed [P_W-1:0] q;
        logic [P_W-1:0]        mask;
        logic [P_W-1:0]        r;
        logic [P_W-1:0]        half;
        q    = x >>> n;
        mask = (P_W'(1) << n) - P_W'(1);
        r    = $unsigned(x) & mask;
        half = P_W'(1) << (n - 3'd1);
        // Round half to even.
        if (rnd && ((r > half) || ((r == half) && q[0]))) begin
            q = q + P_W'(1);
        end
        if (q > P_W'(31)) begin
            q = P_W'(31);
        end else if (q < P_W'(-31)) begin
            q = P_W'(-31);
        end
        return q[cndc_pkg::MIXED_W-1:0];
    endfunction

    always_comb begin
        a = P_W'(i_sample_re);
        b = P_W'(i_sample_im);
        c = P_W'(i_lo_cos);
        d = P_W'(i_lo_nsin);
        re_sum = a * c - b * d;
        im_sum = a * d + b * c;
    end

    assign conv = (i_shift_mode != cndc_pkg::SHIFT_TRUNC3);
    assign sh   = conv ? (cndc_pkg::BASE_SHIFT + {1'b0, i_shift_mode})
                       : cndc_pkg::BASE_SHIFT;

    assign o_mixed_re = scale_sat(re_sum, sh, conv);
    assign o_mixed_im = scale_sat(im_sum, sh, conv);

endmodule

>>> hdl/carrier_nco_downconverter_core.sv
// Top level of the carrier NCO downconverter: register port, sample pipeline, result register.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   sample_re, sample_im
// m_axis    out  m_axis_tvalid/m_axis_tready   mixed_re, mixed_im, carrier_cycles
// apb       in   psel/penable/pwrite/pready    carrier_freq_word @0x0, pre_shift_mode @0x4
//
// One request per clock sustained while m_axis_tready is high; an accepted request goes to
// stage one, then to the result register. The only loops are the 32-bit phase add and the cycle
// count, both stepped at acceptance. Stage one holds the sample with its oscillator tap; the mixer
// fills the result register. A stall on m_axis is absorbed by stage one: if it is empty, one more
// request is taken before s_axis_tready drops.
// Synchronous active-low reset clears phase, cycle count, config registers and valid flags.

module carrier_nco_downconverter_core #(
    parameter int SAMPLE_BITS = 8,
    localparam int S_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sample_re [SAMPLE_BITS-1:0], sample_im [2*SAMPLE_BITS-1:SAMPLE_BITS], zero pad
    input  logic [S_TDATA_W-1:0]              s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // mixed_re [5:0], mixed_im [11:6], carrier_cycles [43:12], zero pad [47:44]
    output logic [cndc_pkg::M_TDATA_W-1:0]    m_axis_tdata,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cndc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cndc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cndc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // Configuration registers
    logic [cndc_pkg::PHASE_W-1:0] r_freq_word;
    logic [1:0]                   r_pre_shift;
    logic                         cfg_wr;
    logic                         reg_sel;

    // Pipeline control
    logic                         s_accept;
    logic                         advance;
    logic                         r_s1_valid;
    logic                         r_out_valid;

    // Stage one payload
    logic signed [SAMPLE_BITS-1:0] r_s1_re;
    logic signed [SAMPLE_BITS-1:0] r_s1_im;
    cndc_pkg::t_nco_tap            r_s1_tap;
    cndc_pkg::t_nco_tap            nco_tap;

    // Result payload
    logic signed [cndc_pkg::MIXED_W-1:0] mix_re;
    logic signed [cndc_pkg::MIXED_W-1:0] mix_im;
    logic signed [cndc_pkg::MIXED_W-1:0] r_out_re;
    logic signed [cndc_pkg::MIXED_W-1:0] r_out_im;
    logic [cndc_pkg::CYCLES_W-1:0]       r_out_cycles;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_word <= '0;
            r_pre_shift <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                cndc_pkg::REG_FREQ_WORD: r_freq_word <= pwdata;
                cndc_pkg::REG_PRE_SHIFT: r_pre_shift <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            cndc_pkg::REG_FREQ_WORD: prdata = r_freq_word;
            cndc_pkg::REG_PRE_SHIFT: prdata = {30'd0, r_pre_shift};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // Advance stage one into the result register whenever that register is free or draining.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // ---------------- oscillator ----------------
    // Step the phase only on an accepted request; the tap uses the phase before the step.
    cndc_nco u_nco (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_accept),
        .i_freq_word (r_freq_word),
        .o_tap       (nco_tap)
    );

    // Capture the sample with its tap.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_re  <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_s1_im  <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_s1_tap <= nco_tap;
        end
    end

    // ---------------- mixer ----------------
    cndc_mixer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mixer (
        .i_sample_re  (r_s1_re),
        .i_sample_im  (r_s1_im),
        .i_lo_cos     (r_s1_tap.lo_cos),
        .i_lo_nsin    (r_s1_tap.lo_nsin),
        .i_shift_mode (r_pre_shift),
        .o_mixed_re   (mix_re),
        .o_mixed_im   (mix_im)
    );

    // Load the result register; hold it while the downstream side stalls.
    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_re     <= mix_re;
            r_out_im     <= mix_im;
            r_out_cycles <= r_s1_tap.cycles;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{cndc_pkg::M_PAD_W{1'b0}}, r_out_cycles, r_out_im, r_out_re};

    // ---------------- assertions ----------------
    // Backpressure reaches the input only when both stages are full and the output stalls.
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_out_valid && !m_axis_tready))
        else $error("s_axis_tready low without a full, stalled pipeline");

    // A held stage one request is never dropped.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> r_s1_valid)
        else $error("stage one request lost during stall");

    // Saturation is symmetric: the most negative code never leaves the block.
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_re != -6'sd32) && (r_out_im != -6'sd32)))
        else $error("mixed output holds the excluded code");

    // A result leaves the pipeline only after it was loaded from stage one.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result valid without a stage one request");

endmodule
